/* rtl/core/udf_pkg.sv */
// types, constants and the crc helper for the uart register datagram framer
// no dependencies; imported by every module of the block

package udf_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_RX    = 2'd2;

	localparam logic [7:0] SYNC_BYTE  = 8'h05;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] WRITE_FLAG = 8'h80;

	// line byte counter positions since arming
	localparam logic [3:0] ECHO_LEN  = 4'd4;
	localparam logic [3:0] VAL_FIRST = 4'd7;
	localparam logic [3:0] RX_LAST   = 4'd11;

	// byte index of the crc in each datagram
	localparam logic [2:0] READ_CRC_IDX  = 3'd3;
	localparam logic [2:0] WRITE_CRC_IDX = 3'd7;

	localparam int FIFO_DEPTH_DEF = 4;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  reg_addr;
		logic [31:0] write_data;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [31:0] read_value;
		logic        reply_status;
	} result_t;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_REPLY = 2'd2
	} cmd_kind_t;

	// one queued job: a request to frame or a finished reply to report
	typedef struct packed {
		cmd_kind_t   kind;
		logic [6:0]  reg_addr;
		logic [31:0] data;
		logic        status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// crc8 poly 0x07, byte fed lsb first
	function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] crc;
		logic       top;
		crc = crc_in;
		for (int i = 0; i < 8; i++) begin
			top = crc[7];
			crc = {crc[6:0], 1'b0};
			if (top ^ b[i])
				crc = crc ^ CRC_POLY;
		end
		return crc;
	endfunction

endpackage

/* rtl/core/udf_chan_if.sv */
// valid/ready channel carrying a payload of any packed type
// used for the item, result and configuration channels; no dependencies

interface udf_chan_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/udf_fifo.sv */
// short command queue between the front and the back of the framer
// depends on udf_pkg for the command and status types

module udf_fifo
	import udf_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_cmd,
	input  logic       pop,
	output cmd_t       head,
	output fifo_stat_t stat
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule

/* rtl/core/udf_front.sv */
// front of the framer: takes items, tracks the reply receiver, queues jobs
// depends on udf_pkg; holds the node address register

module udf_front
	import udf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	udf_chan_if.sink   item,
	udf_chan_if.sink   cfg,
	input  fifo_stat_t stat,
	output logic       push,
	output cmd_t       push_cmd,
	output logic [7:0] node_addr
);
	logic        rx_armed_q;
	logic [3:0]  rx_count_q;
	logic [7:0]  reply_crc_q;
	logic [31:0] reply_value_q;
	logic [7:0]  node_q;

	logic        accept;
	logic        rx_take;
	item_t       it;

	assign it         = item.data;
	assign item.ready = !stat.full;
	assign cfg.ready  = 1'b1;
	assign node_addr  = node_q;
	assign accept     = item.valid && item.ready;
	assign rx_take    = accept && (it.op == OP_RX) && rx_armed_q;

	always_comb begin
		push              = 1'b0;
		push_cmd.kind     = CMD_READ;
		push_cmd.reg_addr = it.reg_addr;
		push_cmd.data     = it.write_data;
		push_cmd.status   = 1'b0;
		if (accept) begin
			case (it.op)
				OP_READ: begin
					push = 1'b1;
				end
				OP_WRITE: begin
					push          = 1'b1;
					push_cmd.kind = CMD_WRITE;
				end
				default: begin
					// reply byte 7 is the crc, checked against bytes 0 to 6
					push            = rx_take && (rx_count_q == RX_LAST);
					push_cmd.kind   = CMD_REPLY;
					push_cmd.data   = reply_value_q;
					push_cmd.status = (it.rx_byte != reply_crc_q);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			node_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_armed_q    <= 1'b0;
			rx_count_q    <= '0;
			reply_crc_q   <= '0;
			reply_value_q <= '0;
		end else if (accept && (it.op == OP_READ)) begin
			rx_armed_q    <= 1'b1;
			rx_count_q    <= '0;
			reply_crc_q   <= '0;
			reply_value_q <= '0;
		end else if (rx_take) begin
			if (rx_count_q == RX_LAST) begin
				rx_armed_q <= 1'b0;
				rx_count_q <= '0;
			end else begin
				rx_count_q <= rx_count_q + 1'b1;
				// echo bytes are skipped
				if (rx_count_q >= ECHO_LEN)
					reply_crc_q <= crc_feed(reply_crc_q, it.rx_byte);
				if (rx_count_q >= VAL_FIRST)
					reply_value_q <= {reply_value_q[23:0], it.rx_byte};
			end
		end
	end
endmodule

/* rtl/core/udf_back.sv */
// back of the framer: turns queued jobs into result items, one per cycle unless stalled
// depends on udf_pkg; drives the output register of the result channel

module udf_back
	import udf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  fifo_stat_t stat,
	input  logic [7:0] node_addr,
	output logic       pop,
	udf_chan_if.source result
);
	logic        out_valid_q;
	result_t     out_q;
	logic [2:0]  idx_q;
	logic [7:0]  crc_q;

	logic        load;
	logic        is_crc;
	logic [7:0]  byte_val;
	result_t     nxt;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;
	assign load         = !stat.empty && (!out_valid_q || result.ready);

	always_comb begin
		case (idx_q)
			3'd0:    byte_val = SYNC_BYTE;
			3'd1:    byte_val = node_addr;
			3'd2:    byte_val = {head.kind == CMD_WRITE, head.reg_addr};
			3'd3:    byte_val = head.data[31:24];
			3'd4:    byte_val = head.data[23:16];
			3'd5:    byte_val = head.data[15:8];
			default: byte_val = head.data[7:0];
		endcase
	end

	assign is_crc = (head.kind == CMD_WRITE) ? (idx_q == WRITE_CRC_IDX)
	                                         : (idx_q == READ_CRC_IDX);

	always_comb begin
		nxt = '0;
		pop = 1'b0;
		if (head.kind == CMD_REPLY) begin
			nxt.kind         = 1'b1;
			nxt.read_value   = head.data;
			nxt.reply_status = head.status;
			pop              = load;
		end else begin
			nxt.tx_byte = is_crc ? crc_q : byte_val;
			nxt.last    = is_crc;
			pop         = load && is_crc;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			crc_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			if (load && (head.kind != CMD_REPLY)) begin
				if (is_crc) begin
					idx_q <= '0;
					crc_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
					crc_q <= crc_feed(crc_q, byte_val);
				end
			end
		end
	end
endmodule

/* rtl/core/uart_register_datagram_framer.sv */
// top level of the uart register datagram framer
// depends on udf_pkg, udf_chan_if, udf_fifo, udf_front and udf_back
//
// usage
//   item carries one request or line byte per transfer: op 0 frames a read
//   (4 bytes), op 1 a write (8 bytes), op 2 hands in a received line byte.
//   result carries one transmit byte per transfer, last set on the crc byte,
//   or one completed read reply with its value and crc status.
//   cfg writes the node address; it is always ready.
// throughput
//   an item is registered in the command queue and then in the output
//   register; the back end emits one result per cycle unless stalled.
//   line bytes produce a result only on the twelfth byte since arming.
//   the front keeps taking items until the command queue (FIFO_DEPTH jobs)
//   fills, which is what bounds the sustained rate to the output byte rate.
// reset
//   clears the queue, the output valid flag, the receiver and the node address.
// stall
//   a result holds in the output register while result.ready is low; the
//   queue absorbs further items and item.ready drops once it is full.

module uart_register_datagram_framer
	import udf_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	udf_chan_if.sink   item,
	udf_chan_if.source result,
	udf_chan_if.sink   cfg
);
	fifo_stat_t stat;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head;
	logic [7:0] node_addr;

	udf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg),
		.stat      (stat),
		.push      (push),
		.push_cmd  (push_cmd),
		.node_addr (node_addr)
	);

	udf_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	udf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.node_addr (node_addr),
		.pop       (pop),
		.result    (result)
	);
endmodule

/* tb/uart_register_datagram_framer_test.sv */
// self-checking testbench for uart_register_datagram_framer
// needs udf_pkg, udf_chan_if and the framer rtl; models datagrams and replies
`timescale 1ns / 100ps

module uart_register_datagram_framer_test
	import udf_pkg::*;
();

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         REPLY_BODY = 7;
	localparam int         DRAIN_CYC  = 8;
	localparam int         DIR_ROWS   = 21;
	localparam int         SEG_ITEMS  = 66;

	localparam result_t SYNC_OUT = '{kind: 1'b0, tx_byte: SYNC_BYTE, last: 1'b0,
		read_value: 32'h0, reply_status: 1'b0};
	localparam result_t ZERO_BAD_REPLY = '{kind: 1'b1, tx_byte: 8'h00, last: 1'b0,
		read_value: 32'h0, reply_status: 1'b1};
	localparam result_t NO_PIN = '0;

	typedef struct {
		item_t   it;
		bit      pin;
		result_t pinned;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	udf_chan_if #(.payload_t(item_t))      item_ch ();
	udf_chan_if #(.payload_t(result_t))    result_ch ();
	udf_chan_if #(.payload_t(logic [7:0])) cfg_ch ();

	uart_register_datagram_framer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// framer state as seen from outside
	logic [7:0]  node_addr;
	logic        armed;
	logic [3:0]  line_cnt;
	logic [7:0]  line_crc;
	logic [31:0] line_val;

	result_t fresh_q [$];
	result_t due_q [$];
	int      acted_cnt;
	int      bad_cnt;
	int      src_idle_pct;
	int      snk_idle_pct;
	row_t    dir_tab [0:DIR_ROWS-1];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = acc;
		for (int k = 0; k < 8; k++) begin
			fb = c[7] ^ b[k];
			c  = c << 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic result_t byte_out(input logic [7:0] b, input logic l);
		return '{kind: 1'b0, tx_byte: b, last: l, read_value: 32'h0, reply_status: 1'b0};
	endfunction

	// fills fresh_q with what the item causes; returns 0 when the item is ignored
	function automatic bit frame_item(input item_t it);
		logic [7:0] dg [0:6];
		int         n;
		logic [3:0] pos;
		logic [7:0] crc;
		fresh_q.delete();
		n = 0;
		case (it.op)
			OP_READ: begin
				dg[0]    = SYNC_BYTE;
				dg[1]    = node_addr;
				dg[2]    = {1'b0, it.reg_addr};
				n        = 3;
				armed    = 1'b1;
				line_cnt = '0;
				line_crc = '0;
				line_val = '0;
			end
			OP_WRITE: begin
				dg[0] = SYNC_BYTE;
				dg[1] = node_addr;
				dg[2] = WRITE_FLAG | {1'b0, it.reg_addr};
				dg[3] = it.write_data[31:24];
				dg[4] = it.write_data[23:16];
				dg[5] = it.write_data[15:8];
				dg[6] = it.write_data[7:0];
				n     = 7;
			end
			OP_RX: begin
				if (!armed)
					return 1'b0;
				pos      = line_cnt;
				line_cnt = pos + 4'd1;
				// echo of our own request is skipped
				if (pos >= ECHO_LEN) begin
					if (pos <= RX_LAST - 4'd1)
						line_crc = crc8_step(line_crc, it.rx_byte);
					if (pos >= VAL_FIRST && pos <= RX_LAST - 4'd1)
						line_val = {line_val[23:0], it.rx_byte};
					if (pos == RX_LAST) begin
						fresh_q.push_back('{kind: 1'b1, tx_byte: 8'h00, last: 1'b0,
							read_value: line_val, reply_status: it.rx_byte != line_crc});
						armed    = 1'b0;
						line_cnt = '0;
					end
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
		crc = '0;
		for (int i = 0; i < n; i++) begin
			fresh_q.push_back(byte_out(dg[i], 1'b0));
			crc = crc8_step(crc, dg[i]);
		end
		fresh_q.push_back(byte_out(crc, 1'b1));
		return 1'b1;
	endfunction

	function automatic row_t mk(input logic [1:0] op, input logic [6:0] a, input logic [31:0] d,
		input logic [7:0] b, input bit pin, input result_t pinned);
		row_t r;
		r.it     = '{op: op, reg_addr: a, write_data: d, rx_byte: b};
		r.pin    = pin;
		r.pinned = pinned;
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 32'h0;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	function automatic item_t rand_req(input logic [1:0] op);
		item_t it;
		it.op         = op;
		it.reg_addr   = 7'($urandom);
		it.write_data = pick_word();
		it.rx_byte    = 8'($urandom);
		return it;
	endfunction

	function automatic item_t rx_item(input logic [7:0] b);
		item_t it;
		it         = rand_req(OP_RX);
		it.rx_byte = b;
		return it;
	endfunction

	task automatic send_item(input item_t it, input bit pin, input result_t pinned);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (frame_item(it))
			acted_cnt++;
		if (pin && fresh_q.size() != 0)
			fresh_q[0] = pinned;
		foreach (fresh_q[i])
			due_q.push_back(fresh_q[i]);
	endtask

	// wait for all results, then let any line byte still in flight settle
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_node(input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		node_addr = v;
	endtask

	// a write or an unused op code slipped into a reply sequence
	task automatic maybe_aside();
		if ($urandom_range(99) < 8) begin
			if ($urandom_range(1) == 1)
				send_item(rand_req(OP_WRITE), 1'b0, NO_PIN);
			else
				send_item(rand_req(OP_UNUSED), 1'b0, NO_PIN);
		end
	endtask

	task automatic run_segment(input int quota);
		int         start;
		int         pick;
		int         n;
		logic [7:0] b;
		logic [7:0] crc;
		start = acted_cnt;
		while (acted_cnt - start < quota) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_item(rand_req(OP_READ), 1'b0, NO_PIN);
				for (int i = 0; i < ECHO_LEN; i++) begin
					maybe_aside();
					send_item(rx_item(pick_byte()), 1'b0, NO_PIN);
				end
				crc = '0;
				for (int i = 0; i < REPLY_BODY; i++) begin
					b   = pick_byte();
					crc = crc8_step(crc, b);
					maybe_aside();
					send_item(rx_item(b), 1'b0, NO_PIN);
				end
				maybe_aside();
				if ($urandom_range(99) < 80)
					send_item(rx_item(crc), 1'b0, NO_PIN);
				else
					send_item(rx_item(crc ^ 8'($urandom_range(255, 1))), 1'b0, NO_PIN);
			end else if (pick < 75) begin
				send_item(rand_req(OP_WRITE), 1'b0, NO_PIN);
			end else if (pick < 85) begin
				n = $urandom_range(3, 1);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(1) == 1)
						send_item(rx_item(8'($urandom)), 1'b0, NO_PIN);
					else
						send_item(rand_req(OP_UNUSED), 1'b0, NO_PIN);
				end
			end else begin
				// reply cut short, the next read has to re-arm
				send_item(rand_req(OP_READ), 1'b0, NO_PIN);
				n = $urandom_range(10, 0);
				for (int i = 0; i < n; i++)
					send_item(rx_item(pick_byte()), 1'b0, NO_PIN);
			end
		end
	endtask

	// result side: check each transfer, then pick ready for the next cycle
	initial begin
		result_t got;
		result_t want;
		bit      diff;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (due_q.size() == 0) begin
					if (bad_cnt < 10)
						$display("unexpected result: kind %0d tx %02h last %0d value %08h st %0d",
							got.kind, got.tx_byte, got.last, got.read_value, got.reply_status);
					bad_cnt++;
				end else begin
					want = due_q.pop_front();
					diff = (got.kind !== want.kind) || (got.tx_byte !== want.tx_byte)
						|| (got.last !== want.last) || (got.read_value !== want.read_value)
						|| (got.reply_status !== want.reply_status);
					if (diff) begin
						if (bad_cnt < 10) begin
							$display("mismatch exp: kind %0d tx %02h last %0d value %08h st %0d",
								want.kind, want.tx_byte, want.last, want.read_value,
								want.reply_status);
							$display("         got: kind %0d tx %02h last %0d value %08h st %0d",
								got.kind, got.tx_byte, got.last, got.read_value,
								got.reply_status);
						end
						bad_cnt++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("[uart_register_datagram_framer] ERROR");
		$finish;
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		arst_n        = 1'b0;
		node_addr     = '0;
		armed         = 1'b0;
		line_cnt      = '0;
		line_crc      = '0;
		line_val      = '0;
		acted_cnt     = 0;
		bad_cnt       = 0;
		src_idle_pct  = 12;
		snk_idle_pct  = 81;

		dir_tab = '{
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'hAA, 1'b0, NO_PIN),  // line byte, not armed
			mk(OP_UNUSED, 7'h7F, 32'hFFFF_FFFF, 8'hFF, 1'b0, NO_PIN),
			mk(OP_WRITE,  7'h7F, 32'hFFFF_FFFF, 8'h00, 1'b1, SYNC_OUT),
			mk(OP_WRITE,  7'h00, 32'h0000_0000, 8'hFF, 1'b1, SYNC_OUT),
			mk(OP_READ,   7'h7F, 32'h1234_5678, 8'h00, 1'b1, SYNC_OUT),
			mk(OP_WRITE,  7'h55, 32'hA5A5_5A5A, 8'h00, 1'b0, NO_PIN),  // write while armed, receiver unaffected
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'hFF, 1'b0, NO_PIN),  // echo
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'hFF, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),  // all-zero reply body
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'hFF, 1'b1, ZERO_BAD_REPLY),
			mk(OP_READ,   7'h00, 32'hFFFF_FFFF, 8'hFF, 1'b1, SYNC_OUT),
			mk(OP_RX,     7'h00, 32'h0000_0000, 8'h12, 1'b0, NO_PIN),
			mk(OP_READ,   7'h2A, 32'h0000_0000, 8'h00, 1'b0, NO_PIN)   // re-arm mid echo
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			send_item(dir_tab[r].it, dir_tab[r].pin, dir_tab[r].pinned);

		for (int seg = 0; seg < 6; seg++) begin
			settle();
			case (seg / 2)
				0: begin
					src_idle_pct = 12;
					snk_idle_pct = 81;
				end
				1: begin
					src_idle_pct = 81;
					snk_idle_pct = 12;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			case (seg)
				0, 4:    write_node(8'hFF);
				2:       write_node(8'h00);
				default: write_node(8'($urandom));
			endcase
			run_segment(SEG_ITEMS);
		end
		settle();

		if (bad_cnt == 0 && due_q.size() == 0)
			$display("[uart_register_datagram_framer] OK");
		else
			$display("[uart_register_datagram_framer] ERROR");
		$finish;
	end

endmodule
